// ===== rtl/core/zsth_pkg.sv =====
// zsth_pkg: shared constants for the Zhang-Suen thinning sub-pass.
// No dependencies; imported by zsth_out_if, the top level and the testbench.
package zsth_pkg;

  localparam int COORD_W  = 10;   // width of the result coordinates
  localparam int SIZE_W   = 11;   // width of the size registers
  localparam int CFG_DW   = 32;   // configuration data width
  localparam int CFG_AW   = 4;    // configuration byte address width
  localparam int MIN_SIZE = 4;    // smallest usable frame edge
  localparam int NB_MIN   = 2;    // fewest set neighbours for removal
  localparam int NB_MAX   = 6;    // most set neighbours for removal

  // register word indexes (byte address / 4)
  localparam logic [1:0] REG_SUB_PASS  = 2'd0;
  localparam logic [1:0] REG_IMG_WIDTH = 2'd1;
  localparam logic [1:0] REG_IMG_HEIGHT = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

endpackage

// ===== rtl/core/zsth_channels.sv =====
// zsth channel interfaces: pixel input beat and result beat, valid/ready.
// Depends on zsth_pkg for the coordinate width.
interface zsth_in_if;
  logic valid;
  logic ready;
  logic pixel_in;
  logic frame_start;

  modport source (output valid, pixel_in, frame_start, input ready);
  modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

interface zsth_out_if import zsth_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               pixel_out;
  logic               removed;

  modport source (output valid, out_row, out_col, pixel_out, removed, input ready);
  modport sink   (input valid, out_row, out_col, pixel_out, removed, output ready);
endinterface

// ===== rtl/core/zsth_ram.sv =====
// zsth_ram: generic single-write, single-read RAM with registered read.
// Read returns the old word on a same-address write. No dependencies.
module zsth_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/zhang_suen_thinning_pass.sv =====
// zhang_suen_thinning_pass: one Zhang-Suen sub-pass over a raster pixel stream.
// Depends on zsth_pkg, zsth_in_if / zsth_out_if and zsth_ram.
// Throughput: one pixel beat per cycle, set by the single RAM read/write per beat,
// unless the output stalls; a taken beat goes to stage 1, then to the output register.
// Reset (rst_n low, synchronous): counters, window and sub-pass clear, sizes take
// SIZE_RESET, then a clearing pass zeroes both line stores; no pixel is taken meanwhile.
module zhang_suen_thinning_pass import zsth_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  zsth_in_if.sink           in_ch,
  zsth_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  // working width for position arithmetic; holds sizes and the size registers
  localparam int SW0 = (CW > RW) ? CW + 1 : RW + 1;
  localparam int SW  = (SW0 > SIZE_W) ? SW0 : SIZE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic              sub_pass_r;
  logic [SIZE_W-1:0] img_w_r;
  logic [SIZE_W-1:0] img_h_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_pass_r <= 1'b0;
      img_w_r    <= SIZE_RESET;
      img_h_r    <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SUB_PASS:   sub_pass_r <= pwdata[0];
        REG_IMG_WIDTH:  img_w_r    <= pwdata[SIZE_W-1:0];
        REG_IMG_HEIGHT: img_h_r    <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_SUB_PASS:   prdata = CFG_DW'(sub_pass_r);
      REG_IMG_WIDTH:  prdata = CFG_DW'(img_w_r);
      REG_IMG_HEIGHT: prdata = CFG_DW'(img_h_r);
      default:        prdata = '0;
    endcase
  end

  // effective frame size, clamped to [MIN_SIZE, MAX_*]
  logic [SW-1:0] w_eff, h_eff;

  always_comb begin
    priority if (SW'(img_w_r) < SW'(MIN_SIZE))  w_eff = SW'(MIN_SIZE);
    else if (SW'(img_w_r) > SW'(MAX_WIDTH))     w_eff = SW'(MAX_WIDTH);
    else                                        w_eff = SW'(img_w_r);
    priority if (SW'(img_h_r) < SW'(MIN_SIZE))  h_eff = SW'(MIN_SIZE);
    else if (SW'(img_h_r) > SW'(MAX_HEIGHT))    h_eff = SW'(MAX_HEIGHT);
    else                                        h_eff = SW'(img_h_r);
  end

  // ---------------------------------------------------------------------------
  // Line store clearing pass after reset
  // ---------------------------------------------------------------------------
  logic          clr_busy_r;
  logic [CW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == CW'(MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position of the incoming beat, line store read
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_cnt_r;
  logic [RW-1:0] row_cnt_r;
  logic [SW-1:0] c0, r0, c_pre, r_pre;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;
  logic          in_acc;
  logic          out_free;
  logic          s1_adv;

  // stage 1 registers
  logic          s1_valid_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_pix_r;
  logic          s1_fwd_r;
  logic          s1_fwd_up_r;
  logic          s1_fwd_mid_r;

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !clr_busy_r && (!s1_valid_r || out_free);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    c_pre = in_ch.frame_start ? '0 : SW'(col_cnt_r);
    r_pre = in_ch.frame_start ? '0 : SW'(row_cnt_r);
    // width shrunk under the counters: step to the next row first
    if (c_pre >= w_eff) begin
      c0 = '0;
      r0 = r_pre + 1'b1;
    end else begin
      c0 = c_pre;
      r0 = r_pre;
    end
    if (r0 >= h_eff) begin
      r0 = '0;
    end
    if (c0 + 1'b1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = (r0 + 1'b1 >= h_eff) ? '0 : RW'(r0 + 1'b1);
    end else begin
      col_nxt = CW'(c0 + 1'b1);
      row_nxt = RW'(r0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      col_cnt_r <= col_nxt;
      row_cnt_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: upper = row two above, middle = row one above
  // ---------------------------------------------------------------------------
  logic          up_q, mid_q;
  logic          up_eff, mid_eff;
  logic          ram_we;
  logic [CW-1:0] ram_waddr;
  logic          up_wdata, mid_wdata;
  logic          fwd_hit;

  assign up_eff  = s1_fwd_r ? s1_fwd_up_r  : up_q;
  assign mid_eff = s1_fwd_r ? s1_fwd_mid_r : mid_q;

  assign ram_we    = clr_busy_r || s1_adv;
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_col_r;
  assign up_wdata  = clr_busy_r ? 1'b0 : mid_eff;
  assign mid_wdata = clr_busy_r ? 1'b0 : s1_pix_r;

  // same column written by stage 1 in the cycle it is read: the RAM returns
  // the old word, so the new one is carried alongside
  assign fwd_hit = s1_adv && (s1_col_r == CW'(c0));

  zsth_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_upper_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (up_wdata),
    .re    (in_acc),
    .raddr (CW'(c0)),
    .rdata (up_q)
  );

  zsth_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_middle_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (mid_wdata),
    .re    (in_acc),
    .raddr (CW'(c0)),
    .rdata (mid_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r     <= CW'(c0);
      s1_row_r     <= RW'(r0);
      s1_pix_r     <= in_ch.pixel_in;
      s1_fwd_r     <= fwd_hit;
      s1_fwd_up_r  <= mid_eff;
      s1_fwd_mid_r <= s1_pix_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: 3x3 window and removal test
  // ---------------------------------------------------------------------------
  logic [5:0] win_r;     // [2:0] column c-1, [5:3] column c-2 (top, mid, bottom)
  logic [2:0] cur, c1, c2;
  logic [7:0] ring, trans;
  logic [3:0] n_trans, n_set;
  logic       m1, m2;
  logic       center, interior, emit, rem;
  logic [SW-1:0] row_m1, col_m1;

  assign cur = {up_eff, mid_eff, s1_pix_r};
  assign c1  = win_r[2:0];
  assign c2  = win_r[5:3];
  assign center = c1[1];

  // ring order from north, clockwise
  assign ring = {c2[2], c2[1], c2[0], c1[0], cur[0], cur[1], cur[2], c1[2]};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      trans[i] = !ring[i] && ring[(i + 1) % 8];
    end
    n_trans = 4'($countones(trans));
    n_set   = 4'($countones(ring));
    if (!sub_pass_r) begin
      m1 = c1[2] & cur[1] & c1[0];   // N.E.S
      m2 = cur[1] & c1[0] & c2[1];   // E.S.W
    end else begin
      m1 = c1[2] & cur[1] & c2[1];   // N.E.W
      m2 = c1[2] & c1[0] & c2[1];    // N.S.W
    end
  end

  assign emit     = (s1_row_r != '0) && (s1_col_r != '0);
  assign interior = (s1_row_r > RW'(1)) && (s1_col_r > CW'(1));
  assign rem      = interior && center && (n_trans == 4'd1) &&
                    (n_set >= 4'(NB_MIN)) && (n_set <= 4'(NB_MAX)) && !m1 && !m2;
  assign row_m1   = SW'(s1_row_r) - 1'b1;
  assign col_m1   = SW'(s1_col_r) - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_adv) begin
      win_r <= {c1, cur};
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic               out_valid_r;
  logic [COORD_W-1:0] out_row_r, out_col_r;
  logic               out_pix_r, out_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_row_r <= row_m1[COORD_W-1:0];
      out_col_r <= col_m1[COORD_W-1:0];
      out_pix_r <= center && !rem;
      out_rem_r <= rem;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.pixel_out = out_pix_r;
  assign out_ch.removed   = out_rem_r;

endmodule

// ===== tb/zhang_suen_thinning_pass_tb.sv =====
// Testbench for zhang_suen_thinning_pass: raster pixel beats in, thinned results checked.
// Depends on zsth_pkg, zsth_in_if / zsth_out_if and the RTL top level.
`timescale 1ns / 1ps

module zhang_suen_thinning_pass_tb import zsth_pkg::*; ();

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;

  // sub-pass register codes
  localparam bit SUB_PASS_FIRST  = 1'b0;
  localparam bit SUB_PASS_SECOND = 1'b1;

  // positions round the 3x3 ring, clockwise from north
  localparam int RING_N  = 0;
  localparam int RING_NE = 1;
  localparam int RING_E  = 2;
  localparam int RING_SE = 3;
  localparam int RING_S  = 4;
  localparam int RING_SW = 5;
  localparam int RING_W  = 6;
  localparam int RING_NW = 7;

  localparam int DRAIN_CYCLES = 6;       // drain after the last result, with margin
  localparam int CYCLE_LIMIT  = 300000;  // several times the slowest legal run
  localparam int MAX_REPORTS  = 100;

  // 4x4 frame holding a 2x2 block in the middle; every interior pixel of it goes
  localparam bit [15:0] SQUARE_4X4 = 16'h0660;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               pix;
    logic               rem;
  } thin_result_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  zsth_in_if  in_ch();
  zsth_out_if out_ch();

  zhang_suen_thinning_pass #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the line stores, window, counters and registers
  // ---------------------------------------------------------------------------
  bit          line_two_up [MAX_W];
  bit          line_one_up [MAX_W];
  bit [5:0]    win_cols = '0;        // c-1 in [2:0], c-2 in [5:3]; top, middle, bottom
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  bit          pass_sel = SUB_PASS_FIRST;
  logic [SIZE_W-1:0] frame_w_reg = SIZE_RESET;
  logic [SIZE_W-1:0] frame_h_reg = SIZE_RESET;

  thin_result_t pending_results[$];   // expected result beats, oldest first
  int           mismatch_count = 0;
  int unsigned  cycle_count = 0;

  // idling chances in percent, hold-off length in cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holdoff_req   = 0;
  int holdoff_left  = 0;

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // frame edge as the block uses it: clamped to [MIN_SIZE, hi]
  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // One accepted pixel beat: update the window and stores, and queue the result
  // for pixel (r-1, c-1) when there is one.
  task automatic thin_predict(input bit pix, input bit fs);
    int unsigned w, h, c, r, a, b;
    logic [2:0]  cur, c1, c2;
    logic [7:0]  ring;
    logic        m1, m2;
    thin_result_t res;
    w = eff_size(frame_w_reg, MAX_W);
    h = eff_size(frame_h_reg, MAX_H);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    // size shrunk under a part-done frame: jump to the next row, wrap the row
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;

    cur = {line_two_up[c], line_one_up[c], pix};
    c1  = win_cols[2:0];
    c2  = win_cols[5:3];

    // nothing for row 0 or column 0 of the incoming stream
    if (r >= 1 && c >= 1) begin
      res.row = COORD_W'(r - 1);
      res.col = COORD_W'(c - 1);
      res.pix = c1[1];
      res.rem = 1'b0;
      // interior only; border pixels pass through as they came
      if (r >= 2 && c >= 2) begin
        ring = {c2[2], c2[1], c2[0], c1[0], cur[0], cur[1], cur[2], c1[2]};
        a = 0;
        for (int i = 0; i < 8; i++)
          if (!ring[i] && ring[(i + 1) % 8]) a++;
        b = $countones(ring);
        if (pass_sel == SUB_PASS_FIRST) begin
          m1 = ring[RING_N] & ring[RING_E] & ring[RING_S];
          m2 = ring[RING_E] & ring[RING_S] & ring[RING_W];
        end else begin
          m1 = ring[RING_N] & ring[RING_E] & ring[RING_W];
          m2 = ring[RING_N] & ring[RING_S] & ring[RING_W];
        end
        if (c1[1] && a == 1 && b >= NB_MIN && b <= NB_MAX && !m1 && !m2) begin
          res.pix = 1'b0;
          res.rem = 1'b1;
        end
      end
      pending_results = {pending_results, res};
    end

    line_two_up[c] = line_one_up[c];
    line_one_up[c] = pix;
    win_cols = {c1, cur};

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready driven at the falling edge, beats checked at the rising
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req != 0) begin
        holdoff_left = holdoff_req;
        holdoff_req  = 0;
      end
      if (holdoff_left != 0) begin
        out_ch.ready = 1'b0;
        holdoff_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    thin_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $error("unexpected result beat: row %0d col %0d", out_ch.out_row, out_ch.out_col);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.out_row !== want.row) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $error("out_row: expected %0d, got %0d", want.row, out_ch.out_row);
        end
        if (out_ch.out_col !== want.col) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $error("out_col: expected %0d, got %0d", want.col, out_ch.out_col);
        end
        if (out_ch.pixel_out !== want.pix) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $error("pixel_out at (%0d,%0d): expected %0d, got %0d",
                   want.row, want.col, want.pix, out_ch.pixel_out);
        end
        if (out_ch.removed !== want.rem) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $error("removed at (%0d,%0d): expected %0d, got %0d",
                   want.row, want.col, want.rem, out_ch.removed);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers; all called at a falling edge and return at one
  // ---------------------------------------------------------------------------
  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // setup cycle then access cycle; register takes the value at the access edge
  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DW-1:0] data);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SUB_PASS:   pass_sel    = data[0];
      REG_IMG_WIDTH:  frame_w_reg = data[SIZE_W-1:0];
      REG_IMG_HEIGHT: frame_h_reg = data[SIZE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // One pixel beat. Valid stays high on return so back-to-back beats need no
  // second assignment in the same step; stream_stop lowers it.
  task automatic send_pixel(input bit pix, input bit fs);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.pixel_in    = pix;
    in_ch.frame_start = fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    thin_predict(pix, fs);
    @(negedge clk);
  endtask

  task automatic send_pixels(input int n, input int density, input bit fs_first);
    for (int i = 0; i < n; i++)
      send_pixel($urandom_range(99) < density, fs_first && i == 0);
  endtask

  task automatic stream_stop();
    in_ch.valid       = 1'b0;
    in_ch.frame_start = 1'b0;
  endtask

  // every result in; then let pixels that owe nothing clear the pipeline
  task automatic settle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Sizes below the minimum clamp to 4x4 (upper bits of the write are dropped).
  // A 2x2 block is thinned by both sub-passes; the two pixels after the first
  // frame wrap to row 0 without frame_start.
  task automatic test_directed_removal();
    cfg_write(REG_SUB_PASS, CFG_DW'(SUB_PASS_FIRST));
    cfg_write(REG_IMG_WIDTH, 32'hFFFF_F803);
    cfg_write(REG_IMG_HEIGHT, 32'd0);
    for (int i = 0; i < 16; i++) send_pixel(SQUARE_4X4[i], i == 0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b0);
    stream_stop();
    settle();
    cfg_write(REG_SUB_PASS, CFG_DW'(SUB_PASS_SECOND));
    for (int i = 0; i < 16; i++) send_pixel(SQUARE_4X4[i], i == 0);
    stream_stop();
    settle();
  endtask

  // Mostly whole frames of random blobs; some continued partial frames (stale
  // window data, counters past a smaller size) and some noise with stray
  // frame_start beats.
  task automatic test_random_frames(input int target);
    int sent, w, h, weff, heff, dens, kind, n, sel;
    sent = 0;
    while (sent < target) begin
      settle();
      sel = $urandom_range(9);
      w   = (sel == 0) ? $urandom_range(0, MIN_SIZE - 1) : $urandom_range(MIN_SIZE, 12);
      sel = $urandom_range(9);
      if (sel == 0)      h = $urandom_range(0, MIN_SIZE - 1);
      else if (sel == 1) h = $urandom_range(MAX_H + 1, 2047);
      else               h = $urandom_range(MIN_SIZE, 10);
      cfg_write(REG_SUB_PASS, $urandom());
      cfg_write(REG_IMG_WIDTH, {21'($urandom_range(0, 2097151)), 11'(w)});
      cfg_write(REG_IMG_HEIGHT, {21'($urandom_range(0, 2097151)), 11'(h)});
      weff = eff_size(SIZE_W'(w), MAX_W);
      heff = eff_size(SIZE_W'(h), MAX_H);
      dens = $urandom_range(2, 9) * 10;
      kind = $urandom_range(99);
      if (kind < 75) begin
        // one or two frames; a tall frame is cut to a few rows
        n = (heff > 12) ? weff * 6 : weff * heff;
        send_pixels(n, dens, 1'b1);
        sent += n;
        if ($urandom_range(1)) begin
          send_pixels(n, dens, 1'($urandom_range(1)));
          sent += n;
        end
      end else if (kind < 90) begin
        n = $urandom_range(1, 3 * weff);
        send_pixels(n, dens, 1'b0);
        sent += n;
      end else begin
        n = $urandom_range(5, 30);
        for (int i = 0; i < n; i++)
          send_pixel($urandom_range(99) < dens, $urandom_range(9) == 0);
        sent += n;
      end
      stream_stop();
    end
    settle();
  endtask

  // Width cut below the column count, then height cut below the row count.
  task automatic test_shrink_mid_frame();
    settle();
    cfg_write(REG_SUB_PASS, $urandom());
    cfg_write(REG_IMG_WIDTH, 32'd10);
    cfg_write(REG_IMG_HEIGHT, 32'd8);
    send_pixels(3 * 10 + 7, 60, 1'b1);
    stream_stop();
    settle();
    cfg_write(REG_IMG_WIDTH, 32'd5);      // column 7 >= 5: next row
    send_pixels(7, 60, 1'b0);
    stream_stop();
    settle();
    cfg_write(REG_IMG_HEIGHT, 32'd4);     // row 5 >= 4: back to row 0
    send_pixels(12, 60, 1'b0);
    stream_stop();
    settle();
  endtask

  // Oversize width and height clamp to the full 1024; a short run stays in
  // row 0, so a row that wraps early shows up as unexpected result beats.
  task automatic test_widest_frame();
    settle();
    cfg_write(REG_SUB_PASS, CFG_DW'(SUB_PASS_SECOND));
    cfg_write(REG_IMG_WIDTH, 32'h0000_07FF);
    cfg_write(REG_IMG_HEIGHT, 32'h0000_07FF);
    send_pixels(64, 50, 1'b1);
    stream_stop();
    settle();
  endtask

  // Receiver holds off for a long stretch while pixels keep coming, so the
  // block backs up and stalls its input; then the sender pauses mid-frame
  // until everything owed has come out.
  task automatic test_backpressure();
    settle();
    cfg_write(REG_SUB_PASS, $urandom());
    cfg_write(REG_IMG_WIDTH, 32'd12);
    cfg_write(REG_IMG_HEIGHT, 32'd10);
    holdoff_req = 400;
    send_pixels(60, 70, 1'b1);
    stream_stop();
    while (pending_results.size() != 0) @(negedge clk);
    send_pixels(60, 70, 1'b0);
    stream_stop();
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.pixel_in    = 1'b0;
    in_ch.frame_start = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    // the line-store clearing pass after reset simply holds off the first beat

    test_directed_removal();

    set_idling(10, 45);
    test_random_frames(130);
    test_shrink_mid_frame();

    set_idling(45, 10);
    test_random_frames(130);
    test_widest_frame();

    set_idling(0, 0);
    test_backpressure();
    test_random_frames(130);

    stream_stop();
    settle();
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/zsth_pkg.sv
rtl/core/zsth_channels.sv
rtl/core/zsth_ram.sv
rtl/core/zhang_suen_thinning_pass.sv
tb/zhang_suen_thinning_pass_tb.sv
